// File: design/rc4_pkg.sv
// rc4_pkg: shared types, codes and the control program of the rc4 stream cipher
// used by rc4_stream_cipher; depends on nothing else
package rc4_pkg;

    localparam int DATA_W    = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int KEY_LEN_W = 6;
    localparam int STEP_W    = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN   = 3'd4;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

    // program steps
    localparam logic [STEP_W-1:0] S_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] S_FILL = 4'd1;
    localparam logic [STEP_W-1:0] S_KRD  = 4'd2;
    localparam logic [STEP_W-1:0] S_K1   = 4'd3;
    localparam logic [STEP_W-1:0] S_K2   = 4'd4;
    localparam logic [STEP_W-1:0] S_K3   = 4'd5;
    localparam logic [STEP_W-1:0] S_KEND = 4'd6;
    localparam logic [STEP_W-1:0] S_G1   = 4'd7;
    localparam logic [STEP_W-1:0] S_G2   = 4'd8;
    localparam logic [STEP_W-1:0] S_G3   = 4'd9;
    localparam logic [STEP_W-1:0] S_G4   = 4'd10;
    localparam logic [STEP_W-1:0] S_G5   = 4'd11;

    // sequencing ops
    localparam logic [1:0] SEQ_NEXT = 2'd0;
    localparam logic [1:0] SEQ_IN   = 2'd1;
    localparam logic [1:0] SEQ_LOOP = 2'd2;
    localparam logic [1:0] SEQ_OUT  = 2'd3;

    // read address select
    localparam logic [2:0] RA_N    = 3'd0;
    localparam logic [2:0] RA_N1   = 3'd1;
    localparam logic [2:0] RA_I1   = 3'd2;
    localparam logic [2:0] RA_JSUM = 3'd3;
    localparam logic [2:0] RA_SUM  = 3'd4;

    // write address select
    localparam logic [1:0] WA_N = 2'd0;
    localparam logic [1:0] WA_I = 2'd1;
    localparam logic [1:0] WA_J = 2'd2;

    // write data select
    localparam logic [1:0] WD_N  = 2'd0;
    localparam logic [1:0] WD_RD = 2'd1;
    localparam logic [1:0] WD_SI = 2'd2;

    // index update ops
    localparam logic [1:0] X_KEEP = 2'd0;
    localparam logic [1:0] X_LOAD = 2'd1;
    localparam logic [1:0] X_CLR  = 2'd2;

    typedef struct packed {
        logic [1:0]        seq;
        logic [STEP_W-1:0] target;
        logic              re;
        logic [2:0]        ra;
        logic              we;
        logic [1:0]        wa;
        logic [1:0]        wd;
        logic [1:0]        j_op;
        logic              use_key;
        logic [1:0]        i_op;
        logic              n_inc;
        logic              k_inc;
        logic              si_ld;
        logic              sj_ld;
        logic              set_init;
    } t_uop;

    function automatic t_uop uop_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        u = '0;
        case (step)
            S_IDLE: begin
                u.seq    = SEQ_IN;
                u.target = S_G1;
            end
            S_FILL: begin
                u.seq    = SEQ_LOOP;
                u.target = S_FILL;
                u.we     = 1'b1;
                u.wa     = WA_N;
                u.wd     = WD_N;
                u.n_inc  = 1'b1;
            end
            S_KRD: begin
                u.re = 1'b1;
                u.ra = RA_N;
            end
            S_K1: begin
                u.re      = 1'b1;
                u.ra      = RA_JSUM;
                u.j_op    = X_LOAD;
                u.use_key = 1'b1;
                u.si_ld   = 1'b1;
            end
            S_K2: begin
                u.we = 1'b1;
                u.wa = WA_N;
                u.wd = WD_RD;
            end
            S_K3: begin
                u.seq    = SEQ_LOOP;
                u.target = S_K1;
                u.we     = 1'b1;
                u.wa     = WA_J;
                u.wd     = WD_SI;
                u.re     = 1'b1;
                u.ra     = RA_N1;
                u.n_inc  = 1'b1;
                u.k_inc  = 1'b1;
            end
            S_KEND: begin
                u.i_op     = X_CLR;
                u.j_op     = X_CLR;
                u.set_init = 1'b1;
            end
            S_G1: begin
                u.re   = 1'b1;
                u.ra   = RA_I1;
                u.i_op = X_LOAD;
            end
            S_G2: begin
                u.re    = 1'b1;
                u.ra    = RA_JSUM;
                u.j_op  = X_LOAD;
                u.si_ld = 1'b1;
            end
            S_G3: begin
                u.we    = 1'b1;
                u.wa    = WA_I;
                u.wd    = WD_RD;
                u.sj_ld = 1'b1;
            end
            S_G4: begin
                u.we = 1'b1;
                u.wa = WA_J;
                u.wd = WD_SI;
                u.re = 1'b1;
                u.ra = RA_SUM;
            end
            S_G5: begin
                u.seq    = SEQ_OUT;
                u.target = S_IDLE;
            end
            default: begin
                u.target = S_IDLE;
                u.seq    = SEQ_OUT;
            end
        endcase
        return u;
    endfunction

endpackage

// File: design/rc4_stream_cipher.sv
// rc4_stream_cipher: byte-wide rc4 encrypt/decrypt with on-demand key schedule
// control runs from the step program in rc4_pkg over a 256 x 8 permutation ram
// depends on rc4_pkg
//
// usage
//   input channel (i_in_valid / o_in_ready) carries one data byte and a message
//   start flag per beat; output channel (o_out_valid / i_out_ready) returns the
//   byte xored with the next keystream byte, one beat per input beat, in order.
//   key bytes and key length are written on the cfg port while the block idles;
//   a new key is used from the next message start on.
// timing
//   o_in_ready is high only while the sequencer sits in its idle step. a beat
//   without start runs steps G1 to G5; its result appears and o_in_ready
//   rises in the same cycle, so a new beat is taken only after the last one
//   is through. a start beat (and the first beat after reset) first runs the
//   key schedule: a fill sweep, then K1 to K3 per permutation entry between KRD
//   and KEND, set by the single permutation ram with one read and one write per cycle.
// reset and stall
//   reset clears indices, the initialized flag, the output slot and the key
//   registers (key length 16). a stalled receiver holds the result in the output
//   register; a new beat is still accepted and is finished once the slot frees.
module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int KEY_BYTES_MAX = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [DATA_W-1:0]    i_data_byte,
    input  logic                 i_message_start,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [DATA_W-1:0]    o_out_byte,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int KPW = $clog2(KEY_BYTES_MAX);

    logic [DATA_W-1:0]    r_key [KEY_BYTES_MAX];
    logic [KEY_LEN_W-1:0] r_key_len;

    logic [STEP_W-1:0]    r_step;
    logic [STEP_W-1:0]    n_step;
    logic [DATA_W-1:0]    r_sweep;
    logic [KPW-1:0]       r_kpos;
    logic [DATA_W-1:0]    r_i;
    logic [DATA_W-1:0]    r_j;
    logic [DATA_W-1:0]    r_si;
    logic [DATA_W-1:0]    r_sj;
    logic [DATA_W-1:0]    r_data;
    logic                 r_init;
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_byte;

    logic [DATA_W-1:0]    r_mem [256];
    logic [DATA_W-1:0]    r_rd;

    t_uop                 w_uop;
    logic                 w_accept;
    logic                 w_need_ks;
    logic                 w_out_free;
    logic                 w_sweep_last;
    logic [KEY_LEN_W-1:0] w_len;
    logic [KEY_LEN_W-1:0] w_kpos_nxt;
    logic [DATA_W-1:0]    w_key_byte;
    logic [DATA_W-1:0]    w_j_sum;
    logic [DATA_W-1:0]    w_raddr;
    logic [DATA_W-1:0]    w_waddr;
    logic [DATA_W-1:0]    w_wdata;

    assign w_uop        = uop_rom(r_step);
    assign o_in_ready   = (r_step == S_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_need_ks    = i_message_start || !r_init;
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_sweep_last = (r_sweep == {DATA_W{1'b1}});
    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;

    // effective key length: zero acts as one, saturate at the key store size
    always_comb begin
        if (r_key_len == '0) begin
            w_len = KEY_LEN_W'(1);
        end else if (r_key_len > KEY_LEN_W'(KEY_BYTES_MAX)) begin
            w_len = KEY_LEN_W'(KEY_BYTES_MAX);
        end else begin
            w_len = r_key_len;
        end
    end

    assign w_kpos_nxt = KEY_LEN_W'(r_kpos) + KEY_LEN_W'(1);
    assign w_key_byte = r_key[r_kpos];
    assign w_j_sum    = r_j + r_rd + (w_uop.use_key ? w_key_byte : '0);

    always_comb begin
        case (w_uop.ra)
            RA_N:    w_raddr = r_sweep;
            RA_N1:   w_raddr = r_sweep + DATA_W'(1);
            RA_I1:   w_raddr = r_i + DATA_W'(1);
            RA_JSUM: w_raddr = w_j_sum;
            RA_SUM:  w_raddr = r_si + r_sj;
            default: w_raddr = r_sweep;
        endcase
    end

    always_comb begin
        case (w_uop.wa)
            WA_N:    w_waddr = r_sweep;
            WA_I:    w_waddr = r_i;
            WA_J:    w_waddr = r_j;
            default: w_waddr = r_sweep;
        endcase
    end

    always_comb begin
        case (w_uop.wd)
            WD_N:    w_wdata = r_sweep;
            WD_RD:   w_wdata = r_rd;
            WD_SI:   w_wdata = r_si;
            default: w_wdata = r_rd;
        endcase
    end

    always_comb begin
        case (w_uop.seq)
            SEQ_NEXT: n_step = r_step + STEP_W'(1);
            SEQ_IN: begin
                if (!w_accept) begin
                    n_step = r_step;
                end else if (w_need_ks) begin
                    n_step = r_step + STEP_W'(1);
                end else begin
                    n_step = w_uop.target;
                end
            end
            SEQ_LOOP: n_step = w_sweep_last ? r_step + STEP_W'(1) : w_uop.target;
            SEQ_OUT:  n_step = w_out_free ? w_uop.target : r_step;
            default:  n_step = S_IDLE;
        endcase
    end

    // permutation ram, write-first on a same-address read
    always_ff @(posedge i_clk) begin
        if (w_uop.we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_uop.re) begin
            if (w_uop.we && (w_waddr == w_raddr)) begin
                r_rd <= w_wdata;
            end else begin
                r_rd <= r_mem[w_raddr];
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < KEY_BYTES_MAX; b++) begin
                r_key[b] <= '0;
            end
            r_key_len <= KEY_LEN_RESET;
        end else if (i_cfg_we) begin
            for (int b = 0; b < KEY_BYTES_MAX; b++) begin
                if (i_cfg_index == CFG_IDX_W'(b >> 3)) begin
                    r_key[b] <= i_cfg_data[(b & 7) * 8 +: 8];
                end
            end
            if (i_cfg_index == CFG_KEY_LEN) begin
                r_key_len <= i_cfg_data[KEY_LEN_W-1:0];
            end
        end
    end

    // sequencer and index registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_sweep     <= '0;
            r_kpos      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_init      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;

            if (w_accept && w_need_ks) begin
                r_sweep <= '0;
                r_kpos  <= '0;
                r_j     <= '0;
            end else begin
                if (w_uop.n_inc) begin
                    r_sweep <= r_sweep + DATA_W'(1);
                end
                if (w_uop.k_inc) begin
                    r_kpos <= (w_kpos_nxt >= w_len) ? '0 : w_kpos_nxt[KPW-1:0];
                end
                case (w_uop.j_op)
                    X_LOAD:  r_j <= w_j_sum;
                    X_CLR:   r_j <= '0;
                    default: r_j <= r_j;
                endcase
            end

            case (w_uop.i_op)
                X_LOAD:  r_i <= r_i + DATA_W'(1);
                X_CLR:   r_i <= '0;
                default: r_i <= r_i;
            endcase

            if (w_uop.set_init) begin
                r_init <= 1'b1;
            end

            if ((w_uop.seq == SEQ_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data <= i_data_byte;
        end
        if (w_uop.si_ld) begin
            r_si <= r_rd;
        end
        if (w_uop.sj_ld) begin
            r_sj <= r_rd;
        end
        if ((w_uop.seq == SEQ_OUT) && w_out_free) begin
            r_out_byte <= r_data ^ r_rd;
        end
    end

    // a new result beat only comes out of the final generation step
    a_out_from_g5: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_step) == S_G5))
        else $error("output beat raised outside the final generation step");

    // a beat on a keyed block goes straight to generation
    a_skip_schedule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_init && !i_message_start) |=> (r_step == S_G1))
        else $error("keyed beat did not enter generation");

    // a start beat enters the fill sweep from entry zero with j cleared
    a_start_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_message_start) |=>
            ((r_step == S_FILL) && (r_sweep == '0) && (r_j == '0)))
        else $error("start beat did not begin the key schedule");

    // no ram write while the block is taking a beat
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_uop.we)
        else $error("permutation written while idle");

endmodule
